// ----- rtl/core/pnf_pkg.sv -----
`default_nettype none

package pnf_pkg;

  localparam int FRAC  = 16;
  localparam int ONE   = 1 << FRAC;
  localparam int OUT_W = 21;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_OCTAVE_COUNT = 2'd0,
    CFG_LACUNARITY   = 2'd1,
    CFG_PERSISTENCE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [7:0]         tbl_idx;
    logic [7:0]         tbl_val;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } item_t;

  typedef struct packed {
    logic [4:0]  octave_count;
    logic [15:0] lacunarity;
    logic [15:0] persistence;
  } cfg_t;

  typedef struct packed {
    logic [1:0] level;
    logic       full;
  } fe_status_t;

  // 12-gradient dot product, picked by the low hash nibble
  function automatic logic signed [18:0] grad_dot(input logic [3:0] h,
                                                  input logic signed [17:0] x,
                                                  input logic signed [17:0] y,
                                                  input logic signed [17:0] z);
    logic signed [18:0] p;
    logic signed [18:0] q;
    p = (h < 4'd8) ? {x[17], x} : {y[17], y};
    if (h < 4'd4) begin
      q = {y[17], y};
    end else if (h == 4'd12 || h == 4'd14) begin
      q = {x[17], x};
    end else begin
      q = {z[17], z};
    end
    if (h[0]) p = -p;
    if (h[1]) q = -q;
    return p + q;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pnf_in_if.sv -----
`default_nettype none

interface pnf_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         table_index;
  logic [7:0]         table_value;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, command, table_index, table_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, command, table_index, table_value, coord_x, coord_y, coord_z,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pnf_out_if.sv -----
`default_nettype none

interface pnf_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] noise_sum;

  modport source (output valid, noise_sum, input ready);
  modport sink (input valid, noise_sum, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/perlin_noise_3d_fbm_top.sv -----
// sequence: a load writes the table while the engine stays idle; an evaluate
// runs scale, fade, table hash, lerp and accumulate per octave, then output;
// no new item is taken until an evaluate ends: the multiplier is shared and
// the table has one read port; a two-beat input queue accepts until it is full
// reset: registers return to 1, 2.0 and 0.5; the queue and output empty;
// the permutation table is not cleared and must be loaded before use
`default_nettype none

module perlin_noise_3d_fbm_top import pnf_pkg::*; #(
  parameter int MAX_OCTAVES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  pnf_in_if.sink           in_i,
  pnf_out_if.source        out_o
);

  cfg_t       cfg_q;
  item_t      item;
  logic       item_valid, item_pop;
  fe_status_t fe_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_count <= 5'd1;
      cfg_q.lacunarity   <= 16'd8192;
      cfg_q.persistence  <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OCTAVE_COUNT: cfg_q.octave_count <= cfg_data_i[4:0];
        CFG_LACUNARITY:   cfg_q.lacunarity   <= cfg_data_i;
        CFG_PERSISTENCE:  cfg_q.persistence  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pnf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .status_o     (fe_status)
  );

  pnf_back #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

  // a full queue must hold off the input side
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_status.full |-> !in_i.ready)
    else $error("input accepted while queue full");

  // each octave contributes at most one
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (int'(out_o.noise_sum) <= MAX_OCTAVES * 65536))
    else $error("octave sum out of range");

  // the engine never pops an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> (fe_status.level != 2'd0))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/pnf_front.sv -----
`default_nettype none

module pnf_front import pnf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pnf_in_if.sink      in_i,
  output item_t       item_o,
  output logic        item_valid_o,
  input  wire logic   item_pop_i,
  output fe_status_t  status_o
);

  item_t      entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] level_q, level_d;
  logic       push, pop;
  item_t      cls;

  assign in_i.ready = (level_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign pop  = item_pop_i && (level_q != 2'd0);

  // keep only the fields that matter for the command
  always_comb begin
    cls.cmd     = cmd_e'(in_i.command);
    cls.tbl_idx = in_i.table_index;
    cls.tbl_val = in_i.table_value;
    cls.cx      = in_i.coord_x;
    cls.cy      = in_i.coord_y;
    cls.cz      = in_i.coord_z;
    if (cls.cmd == CMD_LOAD) begin
      cls.cx = '0;
      cls.cy = '0;
      cls.cz = '0;
    end else begin
      cls.tbl_idx = '0;
      cls.tbl_val = '0;
    end
  end

  always_comb begin
    level_d = level_q;
    if (push && !pop) level_d = level_q + 2'd1;
    if (!push && pop) level_d = level_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      level_q <= level_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= cls;
  end

  assign item_o          = entries_q[rd_ptr_q];
  assign item_valid_o    = (level_q != 2'd0);
  assign status_o.level  = level_q;
  assign status_o.full   = (level_q == 2'd2);

endmodule

`default_nettype wire

// ----- rtl/core/pnf_back.sv -----
`default_nettype none

module pnf_back import pnf_pkg::*; #(
  parameter int MAX_OCTAVES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  cfg_t        cfg_i,
  input  item_t       item_i,
  input  wire logic   item_valid_i,
  output logic        item_pop_o,
  pnf_out_if.source   out_o
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W = FRAC + 1 + OCT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FADE,
    ST_HASH,
    ST_LERP,
    ST_ACCUM,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [20:0] out_sum_q, out_sum_d;

  logic [7:0]  perm_q [256];
  logic [7:0]  raddr, rd_q;

  logic signed [31:0] crd_q [3];
  logic [7:0]         cell_q [3];
  logic [15:0]        frac_q [3];
  logic [16:0]        fade_q [3];
  logic [15:0]        tt_q;
  logic [19:0]        blend_q;
  logic [7:0]         ha_q, hb_q, haa_q, hab_q, hba_q, hbb_q;
  logic signed [18:0] grad_q [8];
  logic signed [18:0] lv_q [7];
  logic [31:0]        freq_q;
  logic [15:0]        amp_q;
  logic [SUM_W-1:0]   sum_q;
  logic [OCT_W-1:0]   left_q, octs;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;

  logic [1:0]         ax;
  logic [15:0]        t_cur;
  logic [19:0]        k15;
  logic [2:0]         gj, gidx;
  logic signed [17:0] gx, gy, gz;
  logic [2:0]         lj;
  logic [16:0]        lt;
  logic signed [18:0] la, lb;
  logic signed [19:0] ldiff;
  logic signed [19:0] half;
  logic [16:0]        oct_val;
  logic [15:0]        pers;
  logic               is_load, is_eval;

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign is_load    = item_pop_o && (item_i.cmd == CMD_LOAD);
  assign is_eval    = item_pop_o && (item_i.cmd == CMD_EVAL);

  always_comb begin
    if (int'(cfg_i.octave_count) > MAX_OCTAVES) octs = OCT_W'(MAX_OCTAVES);
    else octs = OCT_W'(cfg_i.octave_count);
    pers = (cfg_i.persistence > 16'd32768) ? 16'd32768 : cfg_i.persistence;
  end

  // fade axis and its fraction
  assign ax = cnt_q[3:2];
  always_comb begin
    case (ax)
      2'd0:    t_cur = frac_q[0];
      2'd1:    t_cur = frac_q[1];
      2'd2:    t_cur = frac_q[2];
      default: t_cur = '0;
    endcase
  end
  assign k15 = 20'd983040 - ({4'b0, t_cur} << 2) - ({4'b0, t_cur} << 1);

  // corner gradients: beat j of the second hash level lands in corner gidx
  assign gj   = 3'(cnt_q - 4'd7);
  assign gidx = {gj[0], gj[2], gj[1]};
  assign gx   = gidx[0] ? $signed({2'b0, frac_q[0]}) - 18'sd65536 : $signed({2'b0, frac_q[0]});
  assign gy   = gidx[1] ? $signed({2'b0, frac_q[1]}) - 18'sd65536 : $signed({2'b0, frac_q[1]});
  assign gz   = gidx[2] ? $signed({2'b0, frac_q[2]}) - 18'sd65536 : $signed({2'b0, frac_q[2]});

  // lerp operands
  assign lj = cnt_q[3:1];
  always_comb begin
    case (lj)
      3'd0:    begin lt = fade_q[0]; la = grad_q[0]; lb = grad_q[1]; end
      3'd1:    begin lt = fade_q[0]; la = grad_q[2]; lb = grad_q[3]; end
      3'd2:    begin lt = fade_q[0]; la = grad_q[4]; lb = grad_q[5]; end
      3'd3:    begin lt = fade_q[0]; la = grad_q[6]; lb = grad_q[7]; end
      3'd4:    begin lt = fade_q[1]; la = lv_q[0];   lb = lv_q[1];   end
      3'd5:    begin lt = fade_q[1]; la = lv_q[2];   lb = lv_q[3];   end
      default: begin lt = fade_q[2]; la = lv_q[4];   lb = lv_q[5];   end
    endcase
  end
  assign ldiff = {lb[18], lb} - {la[18], la};

  // 0.5 + n/2, clamped to [0, one]
  always_comb begin
    half = (20'sd65536 + $signed({lv_q[6][18], lv_q[6]})) >>> 1;
    if (half < 0) oct_val = '0;
    else if (half > 20'sd65536) oct_val = 17'd65536;
    else oct_val = half[16:0];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SCALE: begin
        case (cnt_q[1:0])
          2'd0:    mul_a = {{2{crd_q[0][31]}}, crd_q[0]};
          2'd1:    mul_a = {{2{crd_q[1][31]}}, crd_q[1]};
          2'd2:    mul_a = {{2{crd_q[2][31]}}, crd_q[2]};
          default: mul_a = '0;
        endcase
        mul_b = {2'b0, freq_q};
      end
      ST_FADE: begin
        case (cnt_q[1:0])
          2'd0:    begin mul_a = {18'b0, t_cur}; mul_b = {18'b0, t_cur}; end
          2'd1:    begin mul_a = {18'b0, t_cur}; mul_b = {14'b0, k15}; end
          2'd2:    begin mul_a = {18'b0, tt_q};  mul_b = {18'b0, t_cur}; end
          default: begin mul_a = {18'b0, prod_q[31:16]}; mul_b = {14'b0, blend_q}; end
        endcase
      end
      ST_LERP: begin
        mul_a = {17'b0, lt};
        mul_b = {{14{ldiff[19]}}, ldiff};
      end
      ST_ACCUM: begin
        case (cnt_q[1:0])
          2'd0:    begin mul_a = {17'b0, oct_val}; mul_b = {18'b0, amp_q}; end
          2'd1:    begin mul_a = {2'b0, freq_q}; mul_b = {18'b0, cfg_i.lacunarity}; end
          default: begin mul_a = {18'b0, amp_q}; mul_b = {18'b0, pers}; end
        endcase
      end
      default: ;
    endcase
  end

  // table read address per hash beat
  always_comb begin
    case (cnt_q)
      4'd0:    raddr = cell_q[0];
      4'd1:    raddr = cell_q[0] + 8'd1;
      4'd2:    raddr = ha_q;
      4'd3:    raddr = ha_q + 8'd1;
      4'd4:    raddr = hb_q;
      4'd5:    raddr = hb_q + 8'd1;
      4'd6:    raddr = haa_q;
      4'd7:    raddr = haa_q + 8'd1;
      4'd8:    raddr = hba_q;
      4'd9:    raddr = hba_q + 8'd1;
      4'd10:   raddr = hab_q;
      4'd11:   raddr = hab_q + 8'd1;
      4'd12:   raddr = hbb_q;
      4'd13:   raddr = hbb_q + 8'd1;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (is_load) perm_q[item_i.tbl_idx] <= item_i.tbl_val;
    rd_q <= perm_q[raddr];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 4'd1;
    out_valid_d = out_valid_q && !out_o.ready;
    out_sum_d   = out_sum_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (is_eval) state_d = (octs == '0) ? ST_OUT : ST_SCALE;
      end
      ST_SCALE: if (cnt_q == 4'd3) begin
        state_d = ST_FADE;
        cnt_d   = '0;
      end
      ST_FADE: if (cnt_q == 4'd12) begin
        state_d = ST_HASH;
        cnt_d   = '0;
      end
      ST_HASH: if (cnt_q == 4'd14) begin
        state_d = ST_LERP;
        cnt_d   = '0;
      end
      ST_LERP: if (cnt_q == 4'd13) begin
        state_d = ST_ACCUM;
        cnt_d   = '0;
      end
      ST_ACCUM: if (cnt_q == 4'd3) begin
        state_d = (left_q == OCT_W'(1)) ? ST_OUT : ST_SCALE;
        cnt_d   = '0;
      end
      ST_OUT: begin
        cnt_d = '0;
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (int'(sum_q) > 32'h1FFFFF) out_sum_d = 21'h1FFFFF;
          else out_sum_d = 21'(sum_q);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_sum_q   <= out_sum_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.noise_sum = out_sum_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: if (is_eval) begin
        crd_q[0] <= item_i.cx;
        crd_q[1] <= item_i.cy;
        crd_q[2] <= item_i.cz;
        freq_q   <= 32'h0001_0000;
        amp_q    <= 16'h8000;
        sum_q    <= '0;
        left_q   <= octs;
      end
      ST_SCALE: begin
        // lattice cell is the product floor wrapped to 8 bits
        case (cnt_q[1:0])
          2'd1:    begin cell_q[0] <= prod_q[39:32]; frac_q[0] <= prod_q[31:16]; end
          2'd2:    begin cell_q[1] <= prod_q[39:32]; frac_q[1] <= prod_q[31:16]; end
          2'd3:    begin cell_q[2] <= prod_q[39:32]; frac_q[2] <= prod_q[31:16]; end
          default: ;
        endcase
      end
      ST_FADE: begin
        case (cnt_q[1:0])
          2'd0: begin
            case (ax)
              2'd1:    fade_q[0] <= prod_q[32:16];
              2'd2:    fade_q[1] <= prod_q[32:16];
              2'd3:    fade_q[2] <= prod_q[32:16];
              default: ;
            endcase
          end
          2'd1:    tt_q    <= prod_q[31:16];
          2'd2:    blend_q <= 20'd655360 - prod_q[35:16];
          default: ;
        endcase
      end
      ST_HASH: begin
        case (cnt_q)
          4'd1:    ha_q  <= rd_q + cell_q[1];
          4'd2:    hb_q  <= rd_q + cell_q[1];
          4'd3:    haa_q <= rd_q + cell_q[2];
          4'd4:    hab_q <= rd_q + cell_q[2];
          4'd5:    hba_q <= rd_q + cell_q[2];
          4'd6:    hbb_q <= rd_q + cell_q[2];
          4'd0:    ;
          default: grad_q[gidx] <= grad_dot(rd_q[3:0], gx, gy, gz);
        endcase
      end
      ST_LERP: if (cnt_q[0]) begin
        // arithmetic shift of the product floors toward minus infinity
        lv_q[lj] <= 19'({{2{la[18]}}, la} + prod_q[36:16]);
      end
      ST_ACCUM: begin
        case (cnt_q[1:0])
          2'd1: sum_q <= sum_q + SUM_W'(prod_q[31:15]);
          2'd2: freq_q <= (prod_q[47:44] != 4'd0) ? 32'hFFFF_FFFF : prod_q[43:12];
          2'd3: begin
            amp_q  <= prod_q[30:15];
            left_q <= left_q - OCT_W'(1);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
